@@ design/mpss_pkg.sv @@
// Shared constants and codes for the middle pop sequence store.
package mpss_pkg;

   localparam int DATA_W           = 32;
   localparam int DEFAULT_CAPACITY = 16;

   localparam int OP_W = 3;
   localparam int ST_W = 2;

   localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OP_W-1:0] OP_TEST   = 3'd2;
   localparam logic [OP_W-1:0] OP_PEEK   = 3'd3;
   localparam logic [OP_W-1:0] OP_POP    = 3'd4;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_UNDER = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

   typedef logic signed [DATA_W-1:0] word_type;

endpackage

@@ design/mpss_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module mpss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/middle_pop_sequence_store.sv @@
// Top level of the middle pop sequence store: sequencer, count and result register.
//
//   Channel | Direction | Beat contents
//   --------+-----------+--------------------------------------------------------
//   req_    | in        | tuser = op (3 bits); tdata = value (32 bits, signed)
//   rsp_    | out       | tdata = data (bits 31:0), found (bit 32), zero fill;
//           |           | tuser = status (2 bits)
//
// One request beat is taken at a time, and req_tready stays low until its response
// is loaded into the output register. All entry traffic goes through one RAM port
// pair with a registered read, so each entry that an operation visits takes a read
// state (S_RD, address) and a use state (S_USE, read data). Append and the trivial
// cases go straight to the result; a test scans from the head to a hit or the tail,
// an insert shifts from the tail then writes the head, a peek reads the middle and a
// pop reads the middle and moves later entries toward the head. A stalled response
// holds the block in its final state until the result register is free. Reset
// (synchronous, active high) clears the count and all control state; the entry RAM
// is not cleared, since only entries below the count are ever read.
module middle_pop_sequence_store
   import mpss_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   // Request channel.
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // value[31:0]
   input  logic [OP_W-1:0]   req_tuser,   // op[2:0]
   // Response channel.
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,   // data[31:0], found[32], zero[39:33]
   output logic [ST_W-1:0]   rsp_tuser    // status[1:0]
);

   // Count needs to hold CAPACITY itself; the RAM address only needs CAPACITY-1.
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   localparam logic [CW-1:0] COUNT_FULL = CW'(CAPACITY);
   localparam logic [CW-1:0] COUNT_ONE  = CW'(1);

   // Sequencer state codes.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;  // present a read address
   localparam logic [2:0] S_USE  = 3'd2;  // read data is valid: shift, compare or capture
   localparam logic [2:0] S_WR0  = 3'd3;  // insert: place the new word at the head
   localparam logic [2:0] S_DONE = 3'd4;  // hand the result to the output register

   logic [2:0]      state_ff, state_in;
   logic [OP_W-1:0] op_ff, op_in;
   word_type        value_ff, value_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   ptr_ff, ptr_in;

   word_type        res_data_ff, res_data_in;
   logic            res_found_ff, res_found_in;
   logic [ST_W-1:0] res_status_ff, res_status_in;

   logic            rsp_valid_ff, rsp_valid_in;
   word_type        rsp_data_ff, rsp_data_in;
   logic            rsp_found_ff, rsp_found_in;
   logic [ST_W-1:0] rsp_status_ff, rsp_status_in;

   logic            mem_wr_en;
   logic [IW-1:0]   mem_wr_addr;
   word_type        mem_wr_data;
   logic            mem_rd_en;
   word_type        mem_rd_data;

   logic [CW-1:0]   mid;
   logic            accept;
   logic            out_free;

   assign mid      = count_ff >> 1;
   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   mpss_ram #(
      .WIDTH(DATA_W),
      .DEPTH(CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (ptr_ff[IW-1:0]),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      res_data_in   = res_data_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = count_ff[IW-1:0];
      mem_wr_data   = value_ff;
      mem_rd_en     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in         = req_tuser;
               value_in      = req_tdata;
               res_data_in   = '0;
               res_found_in  = 1'b0;
               res_status_in = ST_OK;
               state_in      = S_DONE;
               case (req_tuser)
                  OP_APPEND: begin
                     if (count_ff == COUNT_FULL) begin
                        res_status_in = ST_FULL;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = count_ff[IW-1:0];
                        mem_wr_data = req_tdata;
                        count_in    = count_ff + COUNT_ONE;
                     end
                  end
                  OP_INSERT: begin
                     if (count_ff == COUNT_FULL) begin
                        res_status_in = ST_FULL;
                     end else if (count_ff == '0) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = '0;
                        mem_wr_data = req_tdata;
                        count_in    = COUNT_ONE;
                     end else begin
                        // Shift from the tail toward the head.
                        ptr_in   = count_ff - COUNT_ONE;
                        state_in = S_RD;
                     end
                  end
                  OP_TEST: begin
                     if (count_ff != '0) begin
                        ptr_in   = '0;
                        state_in = S_RD;
                     end
                  end
                  OP_PEEK: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_UNDER;
                     end else if (count_ff[0]) begin
                        ptr_in   = mid;
                        state_in = S_RD;
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_UNDER;
                     end else begin
                        ptr_in   = mid;
                        state_in = S_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD: begin
            mem_rd_en = 1'b1;
            state_in  = S_USE;
         end
         S_USE: begin
            case (op_ff)
               OP_INSERT: begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = IW'(ptr_ff + COUNT_ONE);
                  mem_wr_data = mem_rd_data;
                  if (ptr_ff == '0) begin
                     state_in = S_WR0;
                  end else begin
                     ptr_in   = ptr_ff - COUNT_ONE;
                     state_in = S_RD;
                  end
               end
               OP_TEST: begin
                  if (mem_rd_data == value_ff) begin
                     res_found_in = 1'b1;
                     state_in     = S_DONE;
                  end else if (ptr_ff == count_ff - COUNT_ONE) begin
                     state_in = S_DONE;
                  end else begin
                     ptr_in   = ptr_ff + COUNT_ONE;
                     state_in = S_RD;
                  end
               end
               OP_POP: begin
                  // The first read is the middle entry itself; later reads move
                  // each following entry one place toward the head.
                  if (ptr_ff == mid) begin
                     res_data_in = mem_rd_data;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = IW'(ptr_ff - COUNT_ONE);
                     mem_wr_data = mem_rd_data;
                  end
                  if (ptr_ff == count_ff - COUNT_ONE) begin
                     count_in = count_ff - COUNT_ONE;
                     state_in = S_DONE;
                  end else begin
                     ptr_in   = ptr_ff + COUNT_ONE;
                     state_in = S_RD;
                  end
               end
               default: begin
                  // Peek of an odd count: the middle entry is the answer.
                  res_data_in = mem_rd_data;
                  state_in    = S_DONE;
               end
            endcase
         end
         S_WR0: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = '0;
            mem_wr_data = value_ff;
            count_in    = count_ff + COUNT_ONE;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_data_ff;
               rsp_found_in  = res_found_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      value_ff      <= value_in;
      ptr_ff        <= ptr_in;
      res_data_ff   <= res_data_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_found_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the middle pop sequence store, with random stalls on both sides.
`timescale 1ns / 100ps

module testbench;
   import mpss_pkg::*;

   localparam int CAPACITY = DEFAULT_CAPACITY;
   // Longest stretch without any accepted beat before the run is declared hung.
   // The worst legitimate quiet spell is the deliberate receiver hold-off below
   // plus a long idle draw and the slowest operation, well under this figure.
   localparam int QUIET_LIMIT  = 4000;
   localparam int HOLD_CYCLES  = 500;
   localparam int DRAIN_CYCLES = 60;
   localparam int RANDOM_OPS   = 1480;

   // One pending request beat. hold_until_idle makes the sender wait until every
   // response that is owed has come back before offering this beat.
   typedef struct packed {
      logic [OP_W-1:0] op;
      word_type        value;
      logic            hold_until_idle;
   } store_request_type;

   typedef struct packed {
      word_type        data;
      logic            found;
      logic [ST_W-1:0] status;
   } store_result_type;

   // Random runs are biased so the store regularly fills up and drains to empty.
   typedef enum {RUN_GROW, RUN_SHRINK, RUN_MIXED} run_kind_type;

   logic              clock;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata  = '0;
   logic [OP_W-1:0]   req_tuser  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [39:0]       rsp_tdata;   // data[31:0], found[32], zero[39:33]
   logic [ST_W-1:0]   rsp_tuser;   // status[1:0]

   store_request_type pending_requests[$];
   store_result_type  owed_responses[$];

   // Shadow copy of the store, updated as each request beat is accepted.
   word_type    shadow_words[CAPACITY];
   int          shadow_count = 0;
   word_type    value_pool[8];

   int unsigned accepted_requests = 0;
   int unsigned checked_responses = 0;
   int unsigned mismatch_count    = 0;
   int unsigned send_gap          = 0;
   int unsigned recv_stall        = 0;
   int unsigned hold_left         = 0;
   int unsigned holds_done        = 0;
   int unsigned quiet_cycles      = 0;

   middle_pop_sequence_store dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Applies one operation to the shadow store and returns the response it owes.
   function automatic store_result_type apply_store_op(logic [OP_W-1:0] op, word_type value);
      store_result_type r;
      int               mid;
      r = '0;
      case (op)
         OP_APPEND: begin
            if (shadow_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               shadow_words[shadow_count] = value;
               shadow_count++;
            end
         end
         OP_INSERT: begin
            if (shadow_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               for (int i = shadow_count; i > 0; i--) shadow_words[i] = shadow_words[i-1];
               shadow_words[0] = value;
               shadow_count++;
            end
         end
         OP_TEST: begin
            // Only valid entries take part in the search.
            for (int i = 0; i < shadow_count; i++) begin
               if (shadow_words[i] == value) r.found = 1'b1;
            end
         end
         OP_PEEK: begin
            if (shadow_count == 0) begin
               r.status = ST_UNDER;
            end else if (shadow_count % 2 == 1) begin
               r.data = shadow_words[shadow_count/2];
            end
         end
         OP_POP: begin
            if (shadow_count == 0) begin
               r.status = ST_UNDER;
            end else begin
               mid    = shadow_count / 2;
               r.data = shadow_words[mid];
               for (int i = mid; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
               shadow_count--;
            end
         end
         default: begin
            // Unused op codes leave the store alone and answer all zeros.
         end
      endcase
      return r;
   endfunction

   // Idle length for either side. Most draws are short, a few long, and every
   // fourth window of 200 accepted beats runs with no idling at all.
   function automatic int unsigned idle_length();
      int unsigned roll;
      roll = $urandom_range(99);
      if ((accepted_requests / 200) % 4 == 1) return 0;
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // Values come mostly from a small pool so membership tests often hit.
   function automatic word_type pick_value();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 50) return value_pool[$urandom_range(7)];
      if (roll < 60) return value_pool[$urandom_range(3)];
      return $urandom;
   endfunction

   function automatic logic [OP_W-1:0] pick_op(run_kind_type kind);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll >= 97) return 3'($urandom_range(7, 5));
      case (kind)
         RUN_GROW: begin
            if (roll < 40) return OP_APPEND;
            if (roll < 75) return OP_INSERT;
            if (roll < 85) return OP_TEST;
            if (roll < 92) return OP_PEEK;
            return OP_POP;
         end
         RUN_SHRINK: begin
            if (roll < 55) return OP_POP;
            if (roll < 70) return OP_PEEK;
            if (roll < 82) return OP_TEST;
            if (roll < 91) return OP_APPEND;
            return OP_INSERT;
         end
         default: return 3'(roll % 5);
      endcase
   endfunction

   task automatic queue_request(logic [OP_W-1:0] op, word_type value, logic hold);
      store_request_type item;
      item.op              = op;
      item.value           = value;
      item.hold_until_idle = hold;
      pending_requests.insert(pending_requests.size(), item);
   endtask

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t ns: response %0d, %s mismatch: expected %h, actual %h",
                  $time, checked_responses, field, want, got);
      end
   endtask

   // Sender: offers the next pending beat, holds it until taken, then idles for
   // a random number of cycles. The shadow store is updated at acceptance, so
   // the owed response is queued in request order.
   always @(posedge clock) begin
      logic             offer;
      store_result_type owed;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else begin
         offer = req_tvalid && !req_tready;
         if (req_tvalid && req_tready) begin
            owed = apply_store_op(req_tuser, req_tdata);
            owed_responses.insert(owed_responses.size(), owed);
            accepted_requests++;
         end
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
            end else if (pending_requests.size() > 0 &&
                         !(pending_requests[0].hold_until_idle && owed_responses.size() > 0)) begin
               req_tdata <= pending_requests[0].value;
               req_tuser <= pending_requests[0].op;
               void'(pending_requests.pop_front());
               offer = 1'b1;
               send_gap <= idle_length();
            end
         end
         req_tvalid <= offer;
      end
   end

   // Receiver: random stalls, plus two long hold-offs while the sender keeps
   // offering beats, so the block backs up and drops req_tready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall <= 0;
         hold_left  <= 0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if ((holds_done == 0 && accepted_requests >= 300) ||
                   (holds_done == 1 && accepted_requests >= 1000)) begin
         holds_done++;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall <= recv_stall - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         recv_stall <= idle_length();
      end
   end

   // Checker: every response beat is matched against the oldest owed response.
   always @(posedge clock) begin
      store_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         checked_responses++;
         if (owed_responses.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: response beat with none owed: expected nothing, actual %h/%h",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = owed_responses.pop_front();
            check_field("data", want.data, rsp_tdata[31:0]);
            check_field("found", 32'(want.found), 32'(rsp_tdata[32]));
            check_field("status", 32'(want.status), 32'(rsp_tuser));
            check_field("zero fill", 32'd0, 32'(rsp_tdata[39:33]));
         end
      end
   end

   // Watchdog: a long spell with no beat accepted on either channel means a hang.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      run_kind_type    kind;
      int unsigned     run_left;
      int unsigned     real_ops;
      logic [OP_W-1:0] op;

      value_pool[0] = 32'h7FFF_FFFF;
      value_pool[1] = 32'h8000_0000;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

      // Directed opening: the empty store, unused codes, extreme values, even
      // and odd middle peeks, hit and miss searches, and popping back to empty.
      queue_request(OP_PEEK, 32'h1234_5678, 1'b0);       // underflow on empty
      queue_request(OP_POP, 32'hFFFF_FFFF, 1'b0);        // underflow on empty
      queue_request(OP_TEST, 32'h0000_0000, 1'b0);       // nothing held, no hit
      queue_request(3'd5, 32'hFFFF_FFFF, 1'b0);
      queue_request(3'd6, 32'hAAAA_5555, 1'b0);
      queue_request(3'd7, 32'h0000_0000, 1'b0);
      queue_request(OP_APPEND, 32'h7FFF_FFFF, 1'b0);
      queue_request(OP_INSERT, 32'h8000_0000, 1'b0);
      queue_request(OP_PEEK, 32'h0000_0000, 1'b0);       // even count answers zero
      queue_request(OP_APPEND, 32'h0000_0000, 1'b0);
      queue_request(OP_PEEK, 32'h0000_0000, 1'b0);       // odd count, middle entry
      queue_request(OP_TEST, 32'h8000_0000, 1'b0);       // hit at the head
      queue_request(OP_TEST, 32'h7FFF_FFFE, 1'b0);       // near miss
      queue_request(OP_INSERT, 32'hFFFF_FFFF, 1'b0);
      queue_request(OP_TEST, 32'h0000_0000, 1'b0);       // hit at the tail
      for (int i = 0; i < 5; i++) queue_request(OP_POP, 32'h0000_0000, 1'b0);
      queue_request(OP_TEST, 32'h7FFF_FFFF, 1'b0);       // popped words are gone

      // Random part in runs that grow, shrink or mix, so the store keeps
      // reaching both full and empty. Unused op codes do not count as work.
      real_ops = 0;
      run_left = 0;
      kind     = RUN_MIXED;
      while (real_ops < RANDOM_OPS) begin
         if (run_left == 0) begin
            run_left = $urandom_range(60, 10);
            case ($urandom_range(19) / 7)
               0:       kind = RUN_GROW;
               1:       kind = RUN_SHRINK;
               default: kind = RUN_MIXED;
            endcase
         end
         op = pick_op(kind);
         // At two points in the run the sender waits until every response is back.
         queue_request(op, pick_value(), real_ops == 700 || real_ops == 1300);
         if (op <= OP_POP) real_ops++;
         run_left--;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() > 0 || req_tvalid || owed_responses.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ middle_pop_sequence_store.f @@
design/mpss_pkg.sv
design/mpss_ram.sv
design/middle_pop_sequence_store.sv
tb/testbench.sv
